FILE: hdl/ntc_ti_pkg.sv
// shared types, widths and codes of the thermistor table interpolator
package ntc_ti_pkg;

  // fixed field widths
  localparam int ENTRY_W  = 24;
  localparam int SERIES_W = 20;
  localparam int FIRST_W  = 8;
  localparam int STEP_W   = 5;
  localparam int TEMP_W   = 21;
  localparam int INDEX_W  = 6;
  localparam int SAMPLE_W = 12;
  localparam int CFG_IDX_W = 2;
  // interpolated fraction: at most 31 * 256
  localparam int QUOT_W   = 13;
  // width of the temperature sum before clamping
  localparam int TCALC_W  = 24;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK     = 2'd0;
  localparam status_t STATUS_RANGE  = 2'd1;
  localparam status_t STATUS_ZERO   = 2'd2;
  localparam status_t STATUS_LOADED = 2'd3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SERIES = 2'd0;
  localparam cfg_idx_t CFG_FIRST  = 2'd1;
  localparam cfg_idx_t CFG_STEP   = 2'd2;

  localparam logic        CMD_LOAD    = 1'b0;
  localparam logic        CMD_CONVERT = 1'b1;

  localparam logic [SERIES_W-1:0] SERIES_RESET = 20'd12000;
  localparam logic [STEP_W-1:0]   STEP_RESET   = 5'd1;

  localparam logic signed [TEMP_W-1:0]  ERROR_TEMP_Q8 = -21'sd25344;
  localparam logic signed [TCALC_W-1:0] Q8_MAX = 24'sd1048575;
  localparam logic signed [TCALC_W-1:0] Q8_MIN = -24'sd1048576;

  // top level sequencer
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_NUM   = 6'b000010,
    S_LDNUM = 6'b000100,
    S_SCAN  = 6'b001000,
    S_DIVGO = 6'b010000,
    S_DIVW  = 6'b100000
  } seq_state_t;

  // divider sequencer
  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_MUL  = 3'b010,
    D_DIV  = 3'b100
  } div_state_t;

endpackage

FILE: hdl/ntc_ti_div.sv
// shift-add scaling and restoring division for the interpolation fraction
module ntc_ti_div import ntc_ti_pkg::*; #(
  parameter int PROD_W = 37
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] diff,
  input  logic [PROD_W-1:0] span,
  input  logic [STEP_W-1:0] step,
  output logic              done,
  output logic [QUOT_W-1:0] quot
);

  localparam int ACC_W = PROD_W + STEP_W;
  localparam int DIV_W = PROD_W + QUOT_W;

  div_state_t          st_r;
  logic [3:0]          cnt_r;
  logic [STEP_W-1:0]   step_r;
  logic [PROD_W-1:0]   diff_r;
  logic [ACC_W-1:0]    acc_r;
  logic [ACC_W-1:0]    acc_nxt;
  logic [DIV_W-1:0]    rem_r;
  logic [DIV_W-1:0]    den_r;
  logic [QUOT_W-1:0]   q_r;
  logic                done_r;

  // one step of diff * step, msb of step first
  always_comb begin
    acc_nxt = {acc_r[ACC_W-2:0], 1'b0};
    if (step_r[cnt_r[2:0]]) begin
      acc_nxt = acc_nxt + ACC_W'(diff_r);
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      unique case (st_r)
        D_IDLE: begin
          done_r <= 1'b0;
          if (start) begin
            step_r <= step;
            diff_r <= diff;
            acc_r  <= '0;
            den_r  <= DIV_W'(span) << (QUOT_W - 1);
            cnt_r  <= 4'(STEP_W - 1);
            st_r   <= D_MUL;
          end
        end
        D_MUL: begin
          done_r <= 1'b0;
          acc_r  <= acc_nxt;
          if (cnt_r == 4'd0) begin
            rem_r <= {acc_nxt, 8'b0};
            q_r   <= '0;
            cnt_r <= 4'(QUOT_W - 1);
            st_r  <= D_DIV;
          end else begin
            cnt_r <= cnt_r - 4'd1;
          end
        end
        D_DIV: begin
          // one quotient bit per cycle
          if (rem_r >= den_r) begin
            rem_r <= rem_r - den_r;
            q_r   <= {q_r[QUOT_W-2:0], 1'b1};
          end else begin
            q_r   <= {q_r[QUOT_W-2:0], 1'b0};
          end
          den_r <= den_r >> 1;
          if (cnt_r == 4'd0) begin
            done_r <= 1'b1;
            st_r   <= D_IDLE;
          end else begin
            done_r <= 1'b0;
            cnt_r  <= cnt_r - 4'd1;
          end
        end
        default: begin
          done_r <= 1'b0;
          st_r   <= D_IDLE;
        end
      endcase
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

FILE: hdl/ntc_table_interpolator.sv
// thermistor table interpolator: table store, scan sequencer and result stage
//
//  channel  ports                                  handshake
//  in       in_cmd in_entry_index in_entry_ohms    start, accepted while busy low
//           in_adc_code
//  out      out_temperature_q8 out_status          out_valid strobe, one cycle
//  cfg      cfg_index cfg_wdata                    cfg_we, no wait
//
// a load beat or a zero sample gives its result in the cycle after acceptance
// and leaves busy low. a conversion keeps busy high while it scans the table,
// one table entry per cycle through the single memory read port and the shared
// multiplier, then runs the scaling and division steps of the divider.
// a sample outside the table ends once the last entry has been compared.
// reset is synchronous and leaves the table contents unknown until loaded.
// the receiver cannot stall; each result is shown for exactly one cycle.
module ntc_table_interpolator import ntc_ti_pkg::*; #(
  parameter int TABLE_DEPTH = 64,
  parameter int ADC_BITS    = 12
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_cmd,
  input  logic [INDEX_W-1:0]       in_entry_index,
  input  logic [ENTRY_W-1:0]       in_entry_ohms,
  input  logic [SAMPLE_W-1:0]      in_adc_code,
  output logic                     out_valid,
  output logic signed [TEMP_W-1:0] out_temperature_q8,
  output status_t                  out_status,
  input  logic                     cfg_we,
  input  cfg_idx_t                 cfg_index,
  input  logic [SERIES_W-1:0]      cfg_wdata
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = IDX_W + 1;
  localparam int MB_W   = ADC_BITS + 1;
  localparam int PROD_W = ENTRY_W + MB_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [MB_W-1:0]  FULL     = MB_W'(1) << ADC_BITS;

  seq_state_t st_r;
  seq_state_t st_nxt;

  logic [SERIES_W-1:0]       series_r;
  logic signed [FIRST_W-1:0] first_r;
  logic [STEP_W-1:0]         step_r;

  logic [ENTRY_W-1:0]  tbl_mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0]  rd_data_r;
  logic [IDX_W-1:0]    rd_addr;
  logic [CNT_W-1:0]    rd_ptr_r;
  logic                issue;
  logic                rv_r;
  logic [IDX_W-1:0]    ri_r;
  logic                pv_r;
  logic [IDX_W-1:0]    pi_r;

  logic [ADC_BITS-1:0] code_r;
  logic [ADC_BITS-1:0] in_code;
  logic [ENTRY_W-1:0]  mul_a;
  logic [MB_W-1:0]     mul_b;
  logic [PROD_W-1:0]   mul_p_r;
  logic [PROD_W-1:0]   num_r;
  logic [PROD_W-1:0]   hi_prev_r;
  logic                prev_gt_r;
  logic                cur_gt;
  logic                match;
  logic [IDX_W-1:0]    i_r;
  logic [PROD_W-1:0]   diff_r;
  logic [PROD_W-1:0]   span_r;

  logic                div_done;
  logic [QUOT_W-1:0]   div_quot;

  logic                accept;
  logic                out_valid_r;
  logic signed [TEMP_W-1:0] out_temp_r;
  status_t             out_status_r;

  logic [IDX_W+STEP_W-1:0]    istep;
  logic signed [TCALC_W-1:0]  t_sum;
  logic signed [TCALC_W-1:0]  t_clamp;

  assign accept  = start && st_r == S_IDLE;
  assign busy    = st_r != S_IDLE;
  assign in_code = ADC_BITS'(in_adc_code);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      series_r <= SERIES_RESET;
      first_r  <= '0;
      step_r   <= STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SERIES: series_r <= cfg_wdata;
        CFG_FIRST:  first_r  <= FIRST_W'(cfg_wdata);
        CFG_STEP:   step_r   <= STEP_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // table store: written by load beats, read one entry per cycle in the scan
  assign issue   = (st_r == S_LDNUM || st_r == S_SCAN) && rd_ptr_r < CNT_W'(TABLE_DEPTH);
  assign rd_addr = rd_ptr_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (accept && in_cmd == CMD_LOAD && 32'(in_entry_index) < TABLE_DEPTH) begin
      tbl_mem[IDX_W'(in_entry_index)] <= in_entry_ohms;
    end
    rd_data_r <= tbl_mem[rd_addr];
  end

  // shared multiplier: series * (full - code), then entry * code
  always_comb begin
    if (st_r == S_NUM) begin
      mul_a = ENTRY_W'(series_r);
      mul_b = FULL - MB_W'(code_r);
    end else begin
      mul_a = rd_data_r;
      mul_b = MB_W'(code_r);
    end
  end

  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
  end

  // bracket test on the entry whose product is ready
  assign cur_gt = mul_p_r > num_r;
  assign match  = pv_r && pi_r != '0 && prev_gt_r && !cur_gt;

  // sequencer
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (accept && in_cmd == CMD_CONVERT && in_code != '0) begin
          st_nxt = S_NUM;
        end
      end
      S_NUM:   st_nxt = S_LDNUM;
      S_LDNUM: st_nxt = S_SCAN;
      S_SCAN: begin
        if (match) begin
          st_nxt = S_DIVGO;
        end else if (pv_r && pi_r == LAST_IDX) begin
          st_nxt = S_IDLE;
        end
      end
      S_DIVGO: st_nxt = S_DIVW;
      S_DIVW: begin
        if (div_done) begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // scan pipeline: read, multiply, compare
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= 1'b0;
      pv_r <= 1'b0;
    end else begin
      rv_r <= issue;
      pv_r <= rv_r && st_r == S_SCAN;
    end
    ri_r <= rd_addr;
    pi_r <= ri_r;
    if (accept) begin
      code_r <= in_code;
    end
    if (st_r == S_NUM) begin
      rd_ptr_r  <= '0;
      prev_gt_r <= 1'b0;
    end else if (issue) begin
      rd_ptr_r <= rd_ptr_r + CNT_W'(1);
    end
    if (st_r == S_LDNUM) begin
      num_r <= mul_p_r;
    end
    if (st_r == S_SCAN && pv_r) begin
      prev_gt_r <= cur_gt;
      hi_prev_r <= mul_p_r;
    end
    if (match) begin
      i_r    <= pi_r - IDX_W'(1);
      diff_r <= hi_prev_r - num_r;
      span_r <= hi_prev_r - mul_p_r;
    end
  end

  ntc_ti_div #(
    .PROD_W (PROD_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (st_r == S_DIVGO),
    .diff  (diff_r),
    .span  (span_r),
    .step  (step_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  // temperature of the bracket plus the interpolated fraction, clamped
  always_comb begin
    istep = i_r * step_r;
    t_sum = (TCALC_W'(first_r) + $signed(TCALC_W'(istep))) <<< 8;
    t_sum = t_sum + $signed(TCALC_W'(div_quot));
    if (t_sum > Q8_MAX) begin
      t_clamp = Q8_MAX;
    end else if (t_sum < Q8_MIN) begin
      t_clamp = Q8_MIN;
    end else begin
      t_clamp = t_sum;
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      priority if (accept && in_cmd == CMD_LOAD) begin
        out_valid_r  <= 1'b1;
        out_temp_r   <= '0;
        out_status_r <= STATUS_LOADED;
      end else if (accept && in_code == '0) begin
        out_valid_r  <= 1'b1;
        out_temp_r   <= ERROR_TEMP_Q8;
        out_status_r <= STATUS_ZERO;
      end else if (st_r == S_SCAN && !match && pv_r && pi_r == LAST_IDX) begin
        out_valid_r  <= 1'b1;
        out_temp_r   <= ERROR_TEMP_Q8;
        out_status_r <= STATUS_RANGE;
      end else if (st_r == S_DIVW && div_done) begin
        out_valid_r  <= 1'b1;
        out_temp_r   <= TEMP_W'(t_clamp);
        out_status_r <= STATUS_OK;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_temperature_q8 = out_temp_r;
  assign out_status         = out_status_r;

endmodule

FILE: dv/tb_top.sv
// self-checking testbench of the thermistor table interpolator
`timescale 1ns / 1ps

module tb_top;
  import ntc_ti_pkg::*;

  localparam int DEPTH          = 64;
  localparam longint FULL_SCALE = 4096;
  localparam longint ENTRY_MAX  = 64'd16777215;
  localparam int ITEMS_TARGET   = 1550;
  localparam int SETTLE_CYCLES  = 120;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct {
    logic                cmd;
    logic [INDEX_W-1:0]  index;
    logic [ENTRY_W-1:0]  ohms;
    logic [SAMPLE_W-1:0] code;
  } beat_t;

  typedef struct {
    logic signed [TEMP_W-1:0] temp;
    status_t                  status;
  } reading_t;

  typedef enum int {PROFILE_CURVE, PROFILE_FLAT, PROFILE_NOISE, PROFILE_LINEAR} profile_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic in_cmd = 1'b0;
  logic [INDEX_W-1:0] in_entry_index = '0;
  logic [ENTRY_W-1:0] in_entry_ohms = '0;
  logic [SAMPLE_W-1:0] in_adc_code = '0;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_SERIES;
  logic [SERIES_W-1:0] cfg_wdata = '0;
  logic busy;
  logic out_valid;
  logic signed [TEMP_W-1:0] out_temperature_q8;
  status_t out_status;

  // pending commands and the readings they should produce
  beat_t cmd_q[$];
  reading_t reading_q[$];

  // predictor copy of registers and table
  longint unsigned pred_series = 12000;
  int pred_first = 0;
  int pred_step = 1;
  logic [ENTRY_W-1:0] pred_table [DEPTH];

  // stimulus planning copy of the table
  longint unsigned plan_series = 12000;
  logic [ENTRY_W-1:0] plan_table [DEPTH];

  bit beat_taken = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int items_sent = 0;
  int phase_count = 1;
  int errors = 0;
  int idle_cycles = 0;
  int n_loaded = 0;
  int n_ok = 0;
  int n_range = 0;
  int n_zero = 0;

  ntc_table_interpolator u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_cmd             (in_cmd),
    .in_entry_index     (in_entry_index),
    .in_entry_ohms      (in_entry_ohms),
    .in_adc_code        (in_adc_code),
    .out_valid          (out_valid),
    .out_temperature_q8 (out_temperature_q8),
    .out_status         (out_status),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // expected reading for one command, updates the predictor table on loads
  function automatic reading_t predict_reading(input beat_t b);
    reading_t r;
    longint unsigned code, num, hi, lo, span, frac;
    longint base, t;
    bit found;
    r.temp = '0;
    r.status = STATUS_LOADED;
    if (b.cmd == CMD_LOAD) begin
      pred_table[b.index] = b.ohms;
      return r;
    end
    code = b.code;
    r.temp = ERROR_TEMP_Q8;
    if (code == 0) begin
      r.status = STATUS_ZERO;
      return r;
    end
    r.status = STATUS_RANGE;
    num = pred_series * (FULL_SCALE - code);
    found = 1'b0;
    // first falling crossing of the resistance, compared as cross products
    for (int i = 0; i < DEPTH - 1; i++) begin
      hi = longint'(pred_table[i]) * code;
      lo = longint'(pred_table[i+1]) * code;
      if (!found && hi > num && lo <= num) begin
        found = 1'b1;
        span = longint'(pred_table[i] - pred_table[i+1]) * code;
        frac = ((hi - num) * longint'(pred_step) * 256) / span;
        base = longint'(pred_first) + longint'(i) * longint'(pred_step);
        t = base * 256 + $signed(frac);
        if (t > Q8_MAX) t = Q8_MAX;
        if (t < Q8_MIN) t = Q8_MIN;
        r.temp = t[TEMP_W-1:0];
        r.status = STATUS_OK;
      end
    end
    return r;
  endfunction

  // predictor follows register writes
  always @(posedge clk) begin
    if (rst_n && cfg_we) begin
      case (cfg_index)
        CFG_SERIES: pred_series = cfg_wdata;
        CFG_FIRST:  pred_first = int'($signed(cfg_wdata[FIRST_W-1:0]));
        CFG_STEP:   pred_step = int'(cfg_wdata[STEP_W-1:0]);
        default: ;
      endcase
    end
  end

  // input beat acceptance, predicted readings queued in order
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      reading_q.push_back(predict_reading(cmd_q[0]));
      void'(cmd_q.pop_front());
      beat_taken = 1'b1;
    end
  end

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return 0;
    if (r < 7) return $urandom_range(1, 4);
    if (r < 9) return $urandom_range(5, 40);
    return $urandom_range(41, 130);
  endfunction

  // driver: bursts of beats separated by random gaps
  always @(negedge clk) begin
    bit took;
    took = beat_taken;
    beat_taken = 1'b0;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && !took)) begin
      if (took) begin
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = pick_gap();
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        start <= 1'b1;
        in_cmd <= cmd_q[0].cmd;
        in_entry_index <= cmd_q[0].index;
        in_entry_ohms <= cmd_q[0].ohms;
        in_adc_code <= cmd_q[0].code;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: compare each result beat with the oldest predicted reading
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_valid) begin
      if (reading_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: temperature_q8 %0d status %0d",
                 $time, out_temperature_q8, out_status);
      end else begin
        want = reading_q.pop_front();
        if (want.temp !== out_temperature_q8) begin
          errors++;
          $display("%0t temperature_q8 mismatch: expected %0d actual %0d",
                   $time, want.temp, out_temperature_q8);
        end
        if (want.status !== out_status) begin
          errors++;
          $display("%0t status mismatch: expected %0d actual %0d",
                   $time, want.status, out_status);
        end
        case (want.status)
          STATUS_OK:     n_ok++;
          STATUS_RANGE:  n_range++;
          STATUS_ZERO:   n_zero++;
          default:       n_loaded++;
        endcase
      end
    end
  end

  // watchdog on cycles with no accepted beat on either side
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no traffic for %0d cycles", $time, idle_cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_load(input int idx, input longint unsigned ohms);
    beat_t b;
    b.cmd = CMD_LOAD;
    b.index = INDEX_W'(idx);
    b.ohms = ohms[ENTRY_W-1:0];
    b.code = SAMPLE_W'($urandom_range(0, 4095));
    cmd_q.push_back(b);
    plan_table[idx] = ohms[ENTRY_W-1:0];
    items_sent++;
  endtask

  task automatic push_convert(input int code);
    beat_t b;
    b.cmd = CMD_CONVERT;
    b.index = INDEX_W'($urandom_range(0, DEPTH - 1));
    b.ohms = ENTRY_W'($urandom_range(0, 32'hFFFFFF));
    b.code = SAMPLE_W'(code);
    cmd_q.push_back(b);
    items_sent++;
  endtask

  // sample code whose divider resistance is close to the given value
  function automatic int code_for_ohms(input longint unsigned ohms);
    longint unsigned den, c;
    den = plan_series + ohms;
    if (den == 0) return $urandom_range(1, 4095);
    c = (FULL_SCALE * plan_series + den / 2) / den;
    if (c < 1) c = 1;
    if (c > FULL_SCALE - 1) c = FULL_SCALE - 1;
    return int'(c);
  endfunction

  function automatic profile_t pick_profile();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return PROFILE_CURVE;
    if (r < 8) return PROFILE_FLAT;
    if (r < 9) return PROFILE_NOISE;
    return PROFILE_LINEAR;
  endfunction

  // full table reload; curve and flat profiles are scaled to the divider resistor
  task automatic load_table(input profile_t kind);
    longint unsigned v, drop;
    v = plan_series * $urandom_range(2, 60) + $urandom_range(100, 5000);
    if (v > ENTRY_MAX) v = ENTRY_MAX;
    for (int i = 0; i < DEPTH; i++) begin
      case (kind)
        PROFILE_LINEAR: push_load(i, (ENTRY_MAX * (DEPTH - 1 - i)) / (DEPTH - 1));
        PROFILE_NOISE:  push_load(i, $urandom_range(0, 32'hFFFFFF));
        default: begin
          push_load(i, v);
          // flat profile repeats entries now and then
          if (kind == PROFILE_FLAT && $urandom_range(0, 2) == 0) drop = 0;
          else drop = (v * $urandom_range(2, 14)) / 100 + $urandom_range(0, 1);
          v = (drop >= v) ? 0 : v - drop;
        end
      endcase
    end
  endtask

  task automatic push_random_beat();
    int unsigned r;
    int i, code;
    longint unsigned hi, lo, ohms;
    r = $urandom_range(0, 19);
    if (r < 13) begin
      // sample that lands between two neighboring entries
      i = $urandom_range(0, DEPTH - 2);
      hi = plan_table[i];
      lo = plan_table[i+1];
      if (hi > lo) ohms = lo + $urandom_range(0, int'(hi - lo - 1));
      else ohms = hi;
      code = code_for_ohms(ohms) + int'($urandom_range(0, 2)) - 1;
      if (code < 1) code = 1;
      if (code > 4095) code = 4095;
      push_convert(code);
    end else if (r < 16) begin
      push_convert($urandom_range(0, 4095));
    end else if (r == 16) begin
      case ($urandom_range(0, 2))
        0: push_convert(0);
        1: push_convert(1);
        default: push_convert(4095);
      endcase
    end else begin
      // table rewrite mid-stream: nudged entry or noise
      i = $urandom_range(0, DEPTH - 1);
      if ($urandom_range(0, 1)) push_load(i, plan_table[i] ^ (64'd1 << $urandom_range(0, 6)));
      else push_load(i, $urandom_range(0, 32'hFFFFFF));
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [SERIES_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // sender holds off until every reading is back and the block is quiet
  task automatic settle_idle();
    while (cmd_q.size() != 0 || reading_q.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input longint unsigned series, input int first, input int step,
                           input bit reload, input int n_beats);
    settle_idle();
    write_reg(CFG_SERIES, series[SERIES_W-1:0]);
    write_reg(CFG_FIRST, {12'd0, 8'(first)});
    write_reg(CFG_STEP, {15'd0, 5'(step)});
    plan_series = series;
    phase_count++;
    if (reload) load_table(pick_profile());
    repeat (n_beats) push_random_beat();
  endtask

  // stimulus sequence
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // whole table is written before the first conversion
    load_table(PROFILE_CURVE);

    // directed: sample extremes, table edges, out of table on both sides
    push_convert(0);
    push_convert(1);
    push_convert(4095);
    push_convert(2048);
    push_convert(code_for_ohms(plan_table[0]));
    push_convert(code_for_ohms(plan_table[DEPTH-2]));
    push_convert(code_for_ohms((longint'(plan_table[0]) + plan_table[1]) / 2));
    push_convert(code_for_ohms((longint'(plan_table[31]) + plan_table[32]) / 2));
    push_convert(code_for_ohms(longint'(plan_table[0]) * 4));
    push_load(DEPTH - 1, 0);
    push_convert(4095);
    push_load(0, ENTRY_MAX);
    push_convert(1);
    push_convert(code_for_ohms(ENTRY_MAX - 1));
    repeat (50) push_random_beat();

    // register corners, then random settings
    run_phase(10000, -40, 5, 1'b1, 70);
    run_phase(1, -128, 16, 1'b1, 70);
    run_phase(1048575, 127, 1, 1'b1, 70);
    run_phase(0, 25, 3, 1'b1, 50);
    run_phase(4700, -20, 0, 1'b1, 50);
    run_phase(22000, 100, 31, 1'b1, 60);
    run_phase(100000, -1, 2, 1'b0, 60);
    while (items_sent < ITEMS_TARGET) begin
      run_phase(($urandom_range(0, 3) == 0) ? $urandom_range(1, 1048575)
                                           : $urandom_range(1000, 200000),
                int'($urandom_range(0, 255)) - 128, $urandom_range(1, 16),
                $urandom_range(0, 1) != 0, $urandom_range(50, 110));
    end

    settle_idle();
    $display("run covered %0d beats over %0d register settings", items_sent, phase_count);
    $display("results: %0d loads, %0d converted, %0d out of table, %0d zero samples",
             n_loaded, n_ok, n_range, n_zero);
    if (errors == 0 && reading_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
